// File: src/lbb_pkg.sv
// ---------------------------------------------------------------------------
// lbb_pkg
// shared widths, defaults and sizing functions of the line box blur
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbb_pkg;

   localparam int PIX_W           = 8;
   localparam int CSR_W           = 5;
   localparam int MAX_WINDOW_DEF  = 16;
   localparam int MAX_LINE_DEF    = 4096;
   localparam int QUEUE_DEPTH     = 2;
   localparam logic [CSR_W-1:0] WINDOW_RESET = 5'd8;

   function automatic int cnt_width(input int m);
      return $clog2(m + 1);
   endfunction

   function automatic int sum_width(input int m);
      return $clog2(m * ((1 << PIX_W) - 1) + 1);
   endfunction

   function automatic int num_width(input int m);
      return $clog2((m >> 1) + 2);
   endfunction

   function automatic int pos_width(input int l);
      return $clog2(l + 1);
   endfunction

   function automatic int addr_width(input int m);
      return (m > 1) ? $clog2(m) : 1;
   endfunction

   function automatic int entry_width(input int m);
      return 3 * sum_width(m) + cnt_width(m) + num_width(m) + 1;
   endfunction

endpackage

// File: src/lbb_ram.sv
// ---------------------------------------------------------------------------
// lbb_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lbb_front.sv
// ---------------------------------------------------------------------------
// lbb_front
// accepts pixels, keeps window sums, count and history, queues averaging jobs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbb_front #(
   parameter int MAX_WINDOW = lbb_pkg::MAX_WINDOW_DEF,
   parameter int MAX_LINE   = lbb_pkg::MAX_LINE_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_ready,
   input  logic [lbb_pkg::PIX_W-1:0]                    req_red_in,
   input  logic [lbb_pkg::PIX_W-1:0]                    req_green_in,
   input  logic [lbb_pkg::PIX_W-1:0]                    req_blue_in,
   input  logic                                         req_line_end,
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [lbb_pkg::CSR_W-1:0]                    csr_window_size,
   output logic                                         q_push,
   output logic [lbb_pkg::entry_width(MAX_WINDOW)-1:0]  q_data,
   input  logic                                         q_full
);

   import lbb_pkg::*;

   localparam int SW   = sum_width(MAX_WINDOW);
   localparam int CW   = cnt_width(MAX_WINDOW);
   localparam int NW   = num_width(MAX_WINDOW);
   localparam int PW   = pos_width(MAX_LINE);
   localparam int AW   = addr_width(MAX_WINDOW);
   localparam int XW   = ((AW > CW) ? AW : CW) + 1;
   localparam int CMPW = (PW > CW) ? PW : CW;
   localparam int HW   = 3 * PIX_W;

   logic [CSR_W-1:0] win_ff, win_in;
   logic [SW-1:0]    sum_r_ff, sum_r_in, sum_g_ff, sum_g_in, sum_b_ff, sum_b_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic             stale_ff, stale_in;

   logic [CW-1:0]    win_eff;
   logic [CW-1:0]    half;
   logic             sub;
   logic [HW-1:0]    old_word;
   logic [PIX_W-1:0] old_r, old_g, old_b;
   logic [SW-1:0]    sum_r_new, sum_g_new, sum_b_new;
   logic [CW-1:0]    cnt_new;
   logic [XW-1:0]    rd_diff;
   logic [AW-1:0]    rd_addr;
   logic             accept;
   logic             last;
   logic [CMPW-1:0]  pos_cmp, half_cmp;
   logic [NW-1:0]    num;

   lbb_ram #(
      .WIDTH (HW),
      .DEPTH (MAX_WINDOW)
   ) u_hist (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data ({req_red_in, req_green_in, req_blue_in}),
      .rd_addr (rd_addr),
      .rd_data (old_word)
   );

   always_comb begin
      if (win_ff == '0) begin
         win_eff = CW'(1);
      end else if (int'(win_ff) > MAX_WINDOW) begin
         win_eff = CW'(MAX_WINDOW);
      end else begin
         win_eff = CW'(win_ff);
      end
      half = win_eff >> 1;
      sub  = (cnt_ff >= win_eff);

      // oldest word sits count places behind the write pointer
      rd_diff = XW'(wp_ff) - XW'(cnt_ff);
      if (XW'(wp_ff) < XW'(cnt_ff)) begin
         rd_diff = rd_diff + XW'(MAX_WINDOW);
      end
      rd_addr = AW'(rd_diff);

      old_r = sub ? old_word[HW-1:2*PIX_W]      : '0;
      old_g = sub ? old_word[2*PIX_W-1:PIX_W]   : '0;
      old_b = sub ? old_word[PIX_W-1:0]         : '0;

      sum_r_new = sum_r_ff + SW'(req_red_in)   - SW'(old_r);
      sum_g_new = sum_g_ff + SW'(req_green_in) - SW'(old_g);
      sum_b_new = sum_b_ff + SW'(req_blue_in)  - SW'(old_b);
      cnt_new   = sub ? cnt_ff : cnt_ff + CW'(1);

      last     = req_line_end || (pos_ff >= PW'(MAX_LINE - 1));
      pos_cmp  = CMPW'(pos_ff);
      half_cmp = CMPW'(half);
      if (last) begin
         num = (pos_cmp < half_cmp) ? NW'(pos_ff) + NW'(1) : NW'(half) + NW'(1);
      end else begin
         num = (pos_cmp >= half_cmp) ? NW'(1) : '0;
      end

      req_ready = !stale_ff && !q_full;
      csr_ready = 1'b1;
      accept    = req_valid && req_ready;
      q_push    = accept && (num != '0);
      q_data    = {sum_r_new, sum_g_new, sum_b_new, cnt_new, num, last};

      win_in   = (csr_valid && csr_ready) ? csr_window_size : win_ff;
      stale_in = accept;
      sum_r_in = sum_r_ff;
      sum_g_in = sum_g_ff;
      sum_b_in = sum_b_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      wp_in    = wp_ff;
      if (accept) begin
         if (last) begin
            sum_r_in = '0;
            sum_g_in = '0;
            sum_b_in = '0;
            cnt_in   = '0;
            pos_in   = '0;
            wp_in    = '0;
         end else begin
            sum_r_in = sum_r_new;
            sum_g_in = sum_g_new;
            sum_b_in = sum_b_new;
            cnt_in   = cnt_new;
            pos_in   = pos_ff + PW'(1);
            wp_in    = (wp_ff == AW'(MAX_WINDOW - 1)) ? '0 : wp_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= WINDOW_RESET;
         sum_r_ff <= '0;
         sum_g_ff <= '0;
         sum_b_ff <= '0;
         cnt_ff   <= '0;
         pos_ff   <= '0;
         wp_ff    <= '0;
         stale_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         sum_r_ff <= sum_r_in;
         sum_g_ff <= sum_g_in;
         sum_b_ff <= sum_b_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         wp_ff    <= wp_in;
         stale_ff <= stale_in;
      end
   end

endmodule

// File: src/lbb_queue.sv
// ---------------------------------------------------------------------------
// lbb_queue
// small fifo of averaging jobs between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbb_queue #(
   parameter int WIDTH = 46,
   parameter int DEPTH = lbb_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   always_comb begin
      full     = (fill_ff == FILL_W'(DEPTH));
      empty    = (fill_ff == '0);
      pop_data = mem_ff[rd_ptr_ff];
      do_push  = push && !full;
      do_pop   = pop && !empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// File: src/lbb_back.sv
// ---------------------------------------------------------------------------
// lbb_back
// divides the three window sums by the count and sends the result words
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbb_back #(
   parameter int MAX_WINDOW = lbb_pkg::MAX_WINDOW_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         q_empty,
   input  logic [lbb_pkg::entry_width(MAX_WINDOW)-1:0]  q_data,
   output logic                                         q_pop,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic [lbb_pkg::PIX_W-1:0]                    rsp_red_out,
   output logic [lbb_pkg::PIX_W-1:0]                    rsp_green_out,
   output logic [lbb_pkg::PIX_W-1:0]                    rsp_blue_out,
   output logic                                         rsp_line_last
);

   import lbb_pkg::*;

   localparam int SW  = sum_width(MAX_WINDOW);
   localparam int CW  = cnt_width(MAX_WINDOW);
   localparam int NW  = num_width(MAX_WINDOW);
   localparam int DW  = CW + PIX_W;
   localparam int STW = $clog2(PIX_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic [STW-1:0] step_ff, step_in;
   logic [DW-1:0]  acc_r_ff, acc_r_in, acc_g_ff, acc_g_in, acc_b_ff, acc_b_in;
   logic [CW-1:0]  div_ff, div_in;
   logic [NW-1:0]  left_ff, left_in;
   logic           last_ff, last_in;

   logic [SW-1:0]  q_sum_r, q_sum_g, q_sum_b;
   logic [CW-1:0]  q_cnt;
   logic [NW-1:0]  q_num;
   logic           q_last;

   // one restoring step: remainder on top, dividend bits out, quotient bits in
   function automatic logic [DW-1:0] div_step(input logic [DW-1:0] a,
                                              input logic [CW-1:0] d);
      logic [DW:0] sh;
      logic [CW:0] top;
      sh  = {a, 1'b0};
      top = sh[DW:PIX_W];
      if (top >= {1'b0, d}) begin
         top   = top - {1'b0, d};
         sh[0] = 1'b1;
      end
      return {top[CW-1:0], sh[PIX_W-1:0]};
   endfunction

   always_comb begin
      {q_sum_r, q_sum_g, q_sum_b, q_cnt, q_num, q_last} = q_data;

      state_in = state_ff;
      step_in  = step_ff;
      acc_r_in = acc_r_ff;
      acc_g_in = acc_g_ff;
      acc_b_in = acc_b_ff;
      div_in   = div_ff;
      left_in  = left_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               acc_r_in = DW'(q_sum_r);
               acc_g_in = DW'(q_sum_g);
               acc_b_in = DW'(q_sum_b);
               div_in   = q_cnt;
               left_in  = q_num;
               last_in  = q_last;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            acc_r_in = div_step(acc_r_ff, div_ff);
            acc_g_in = div_step(acc_g_ff, div_ff);
            acc_b_in = div_step(acc_b_ff, div_ff);
            step_in  = step_ff + STW'(1);
            if (step_ff == STW'(PIX_W - 1)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_ready) begin
               left_in = left_ff - NW'(1);
               if (left_ff == NW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = (state_ff == ST_SEND);
   assign rsp_red_out   = acc_r_ff[PIX_W-1:0];
   assign rsp_green_out = acc_g_ff[PIX_W-1:0];
   assign rsp_blue_out  = acc_b_ff[PIX_W-1:0];
   assign rsp_line_last = last_ff && (left_ff == NW'(1));

   always_ff @(posedge clock) begin
      acc_r_ff <= acc_r_in;
      acc_g_ff <= acc_g_in;
      acc_b_ff <= acc_b_in;
      div_ff   <= div_in;
      step_ff  <= step_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
      end
   end

endmodule

// File: src/line_box_blur_top.sv
// ---------------------------------------------------------------------------
// line_box_blur_top
// one-line rgb moving-average blur with a growing window at the line start
// front stalls the next pixel while the registered history ram read is pending
// a queued job is loaded, then goes through the bit-serial divider
// then its results leave one per cycle while rsp_ready is high, up to W/2+1 words
// synchronous reset clears sums, count, position, queue and window (8);
// the pixel history ram is not cleared
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_box_blur_top #(
   parameter int MAX_WINDOW = lbb_pkg::MAX_WINDOW_DEF,
   parameter int MAX_LINE   = lbb_pkg::MAX_LINE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [lbb_pkg::PIX_W-1:0] req_red_in,
   input  logic [lbb_pkg::PIX_W-1:0] req_green_in,
   input  logic [lbb_pkg::PIX_W-1:0] req_blue_in,
   input  logic                      req_line_end,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [lbb_pkg::PIX_W-1:0] rsp_red_out,
   output logic [lbb_pkg::PIX_W-1:0] rsp_green_out,
   output logic [lbb_pkg::PIX_W-1:0] rsp_blue_out,
   output logic                      rsp_line_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lbb_pkg::CSR_W-1:0] csr_window_size
);

   import lbb_pkg::*;

   localparam int EW = entry_width(MAX_WINDOW);

   logic          q_push, q_full, q_pop, q_empty;
   logic [EW-1:0] q_in_data, q_out_data;

   lbb_front #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_LINE   (MAX_LINE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_line_end    (req_line_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_window_size (csr_window_size),
      .q_push          (q_push),
      .q_data          (q_in_data),
      .q_full          (q_full)
   );

   lbb_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   lbb_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_data        (q_out_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_line_last (rsp_line_last)
   );

endmodule
